@@ src/sms_pkg.sv @@
// shared constants, types and the index swizzle function of the swizzled mip level stream
// no dependencies; every other file but sms_ram refers to it by scoped names
`default_nettype none
package sms_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_LOG2  = $clog2(MAX_DIM);
  localparam int COORD_W   = DIM_LOG2;
  localparam int IDX_W     = 2 * COORD_W;
  localparam int RIDX_W    = IDX_W - 2;
  localparam int SLOTS     = MAX_DIM / 2;
  localparam int SLOT_W    = COORD_W - 1;
  localparam int CH_W      = 8;
  localparam int PS_W      = CH_W + 1;
  localparam int NCH       = 4;
  localparam int LOG2_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic [LOG2_W-1:0] LOG2_LIMIT = LOG2_W'(DIM_LOG2);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_ENABLE = 2'd2;

  typedef logic [NCH-1:0][CH_W-1:0] pixel_t;
  typedef logic [NCH-1:0][PS_W-1:0] pair_t;

  // one pixel between the front stage and the output stage
  typedef struct packed {
    logic [IDX_W-1:0]  swizzled_index;
    pixel_t            px;
    logic              emit;
    logic              use_mem;
    logic [RIDX_W-1:0] reduced_index;
    pair_t             ps;
  } stage_t;

  // low s bits interleaved (x odd, y even), remaining high bits stacked above
  function automatic logic [IDX_W-1:0] swizzle(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [LOG2_W-1:0] s);
    logic [IDX_W-1:0]   il;
    logic [COORD_W-1:0] hi;
    il = '0;
    for (int b = 0; b < COORD_W; b++) begin
      if (b < int'(s)) begin
        il[2*b+1] = x[b];
        il[2*b]   = y[b];
      end
    end
    hi = (x | y) >> s;
    return il | ({{COORD_W{1'b0}}, hi} << {s, 1'b0});
  endfunction

endpackage
`default_nettype wire

@@ src/sms_ifs.sv @@
// valid/ready channel interfaces: pixel input, result output, register writes
// depends on sms_pkg
`default_nettype none
interface sms_in_if;
  logic                     valid;
  logic                     ready;
  logic [sms_pkg::CH_W-1:0] red;
  logic [sms_pkg::CH_W-1:0] green;
  logic [sms_pkg::CH_W-1:0] blue;
  logic [sms_pkg::CH_W-1:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface sms_out_if;
  logic                       valid;
  logic                       ready;
  logic [sms_pkg::IDX_W-1:0]  swizzled_index;
  logic [sms_pkg::CH_W-1:0]   out_red;
  logic [sms_pkg::CH_W-1:0]   out_green;
  logic [sms_pkg::CH_W-1:0]   out_blue;
  logic [sms_pkg::CH_W-1:0]   out_alpha;
  logic                       reduced_valid;
  logic [sms_pkg::RIDX_W-1:0] reduced_index;
  logic [sms_pkg::CH_W-1:0]   reduced_red;
  logic [sms_pkg::CH_W-1:0]   reduced_green;
  logic [sms_pkg::CH_W-1:0]   reduced_blue;
  logic [sms_pkg::CH_W-1:0]   reduced_alpha;
  modport source (output valid, swizzled_index, out_red, out_green, out_blue, out_alpha,
                  reduced_valid, reduced_index, reduced_red, reduced_green, reduced_blue,
                  reduced_alpha, input ready);
  modport sink   (input valid, swizzled_index, out_red, out_green, out_blue, out_alpha,
                  reduced_valid, reduced_index, reduced_red, reduced_green, reduced_blue,
                  reduced_alpha, output ready);
endinterface

interface sms_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sms_pkg::CFG_IDX_W-1:0] index;
  logic [sms_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/sms_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none
module sms_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/sms_front.sv @@
// front stage: registers, raster counters, swizzle, horizontal pair sums, line-store access
// depends on sms_pkg, sms_ifs
`default_nettype none
module sms_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  sms_in_if.sink                        in_ch,
  sms_cfg_if.sink                       cfg_ch,
  input  wire logic                     out_ld,
  output logic                          s1_valid,
  output sms_pkg::stage_t               s1,
  output logic                          ram_we,
  output logic                          ram_re,
  output logic [sms_pkg::SLOT_W-1:0]    ram_addr,
  output sms_pkg::pair_t                ram_wdata
);

  logic [sms_pkg::LOG2_W-1:0]  width_log2_r, height_log2_r;
  logic                        reduce_r;
  logic [sms_pkg::COORD_W-1:0] column_r, row_r;
  logic [sms_pkg::COORD_W-1:0] column_nxt, row_nxt;
  sms_pkg::pixel_t             pair_sum_r;
  logic                        s1_valid_r;
  sms_pkg::stage_t             s1_r, s1_nxt;

  logic [sms_pkg::LOG2_W-1:0]  wl, hl, s, nwl, nhl, rs;
  logic [sms_pkg::COORD_W-1:0] x, y;
  logic [sms_pkg::COORD_W:0]   xn, yn;
  sms_pkg::pixel_t             px;
  sms_pkg::pair_t              ps;
  logic                        hready, pair_ld, emit, use_mem, wr_row;
  logic                        s1_adv, accept, cfg_wr;
  logic [sms_pkg::IDX_W-1:0]   rswz;

  assign s1_adv       = !s1_valid_r || out_ld;
  assign in_ch.ready  = s1_adv;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && s1_adv;
  assign cfg_wr       = cfg_ch.valid;

  always_comb begin
    wl  = (width_log2_r  > sms_pkg::LOG2_LIMIT) ? sms_pkg::LOG2_LIMIT : width_log2_r;
    hl  = (height_log2_r > sms_pkg::LOG2_LIMIT) ? sms_pkg::LOG2_LIMIT : height_log2_r;
    s   = (wl < hl) ? wl : hl;
    nwl = (wl != '0) ? wl - 4'd1 : '0;
    nhl = (hl != '0) ? hl - 4'd1 : '0;
    rs  = (nwl < nhl) ? nwl : nhl;
    x   = ((column_r >> wl) != '0) ? '0 : column_r;
    y   = ((row_r >> hl) != '0) ? '0 : row_r;
    px  = {in_ch.alpha, in_ch.blue, in_ch.green, in_ch.red};

    hready  = 1'b0;
    pair_ld = 1'b0;
    ps      = '0;
    if (wl == '0) begin
      // single column: pixel counts twice
      for (int c = 0; c < sms_pkg::NCH; c++) ps[c] = {px[c], 1'b0};
      hready = 1'b1;
    end else if (!x[0]) begin
      pair_ld = 1'b1;
    end else begin
      for (int c = 0; c < sms_pkg::NCH; c++) ps[c] = {1'b0, pair_sum_r[c]} + {1'b0, px[c]};
      hready = 1'b1;
    end

    emit    = 1'b0;
    use_mem = 1'b0;
    wr_row  = 1'b0;
    if (reduce_r && hready) begin
      if (hl == '0) begin
        emit = 1'b1;
      end else if (!y[0]) begin
        wr_row = 1'b1;
      end else begin
        emit    = 1'b1;
        use_mem = 1'b1;
      end
    end

    rswz = sms_pkg::swizzle({1'b0, x[sms_pkg::COORD_W-1:1]},
                            {1'b0, y[sms_pkg::COORD_W-1:1]}, rs);

    s1_nxt.swizzled_index = sms_pkg::swizzle(x, y, s);
    s1_nxt.px             = px;
    s1_nxt.emit           = emit;
    s1_nxt.use_mem        = use_mem;
    s1_nxt.reduced_index  = rswz[sms_pkg::RIDX_W-1:0];
    s1_nxt.ps             = ps;

    // raster advance with wrap at the end of a row and of the level
    xn = {1'b0, x} + {{sms_pkg::COORD_W{1'b0}}, 1'b1};
    yn = {1'b0, y} + {{sms_pkg::COORD_W{1'b0}}, 1'b1};
    column_nxt = xn[sms_pkg::COORD_W-1:0];
    row_nxt    = y;
    if ((xn >> wl) != '0) begin
      column_nxt = '0;
      row_nxt    = ((yn >> hl) != '0) ? '0 : yn[sms_pkg::COORD_W-1:0];
    end
  end

  assign ram_we    = accept && wr_row;
  assign ram_re    = accept && use_mem;
  assign ram_addr  = x[sms_pkg::COORD_W-1:1];
  assign ram_wdata = ps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_log2_r  <= '0;
      height_log2_r <= '0;
      reduce_r      <= 1'b0;
      column_r      <= '0;
      row_r         <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_ch.index)
          sms_pkg::REG_WIDTH_LOG2: begin
            width_log2_r <= cfg_ch.data;
            column_r     <= '0;
            row_r        <= '0;
          end
          sms_pkg::REG_HEIGHT_LOG2: begin
            height_log2_r <= cfg_ch.data;
            column_r      <= '0;
            row_r         <= '0;
          end
          sms_pkg::REG_REDUCE_ENABLE: begin
            reduce_r <= cfg_ch.data[0];
            column_r <= '0;
            row_r    <= '0;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        column_r <= column_nxt;
        row_r    <= row_nxt;
      end
      if (s1_adv) begin
        s1_valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (accept && pair_ld) begin
      pair_sum_r <= px;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule
`default_nettype wire

@@ src/sms_back.sv @@
// output stage: vertical sum with the line store, rounded 2x2 average, result register
// depends on sms_pkg, sms_ifs
`default_nettype none
module sms_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            s1_valid,
  input  wire sms_pkg::stage_t s1,
  input  wire sms_pkg::pair_t  ram_rdata,
  output logic                 out_ld,
  sms_out_if.source            out_ch
);

  logic                        out_valid_r;
  logic [sms_pkg::IDX_W-1:0]   swz_r;
  sms_pkg::pixel_t             px_r;
  logic                        red_valid_r;
  logic [sms_pkg::RIDX_W-1:0]  red_index_r;
  sms_pkg::pixel_t             avg_r, avg_nxt;
  logic [sms_pkg::PS_W:0]      tot;

  assign out_ld = !out_valid_r || out_ch.ready;

  always_comb begin
    avg_nxt = '0;
    for (int c = 0; c < sms_pkg::NCH; c++) begin
      tot = s1.use_mem ? ({1'b0, ram_rdata[c]} + {1'b0, s1.ps[c]}) : {s1.ps[c], 1'b0};
      tot = tot + 10'd2;
      if (s1.emit) avg_nxt[c] = tot[sms_pkg::PS_W:2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && s1_valid) begin
      swz_r       <= s1.swizzled_index;
      px_r        <= s1.px;
      red_valid_r <= s1.emit;
      red_index_r <= s1.emit ? s1.reduced_index : '0;
      avg_r       <= avg_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.swizzled_index = swz_r;
  assign out_ch.out_red        = px_r[0];
  assign out_ch.out_green      = px_r[1];
  assign out_ch.out_blue       = px_r[2];
  assign out_ch.out_alpha      = px_r[3];
  assign out_ch.reduced_valid  = red_valid_r;
  assign out_ch.reduced_index  = red_index_r;
  assign out_ch.reduced_red    = avg_r[0];
  assign out_ch.reduced_green  = avg_r[1];
  assign out_ch.reduced_blue   = avg_r[2];
  assign out_ch.reduced_alpha  = avg_r[3];

endmodule
`default_nettype wire

@@ src/swizzled_mip_level_stream.sv @@
// top level of the swizzled mip level stream: front stage, line store ram, output stage
// depends on sms_pkg, sms_ifs, sms_ram, sms_front, sms_back
`default_nettype none
// Takes one RGBA8 pixel per clock in raster order unless the output stalls and returns it
// from the result register with its swizzled index and, when reduction is on, the rounded
// 2x2 average that the pixel completes. Each pixel makes at most one access to the line
// store, a 2048 x 36 single-port-write ram holding the horizontal pair sums of the even
// row, which the odd row reads back ahead of the output stage. A width, height or reduce
// write restarts the level at (0,0); the user must write registers only while no pixel is
// in flight, unenforced by the block. The line store needs no clearing after reset.
module swizzled_mip_level_stream (
  input wire logic  clk,
  input wire logic  rst_n,
  sms_in_if.sink    in_ch,
  sms_out_if.source out_ch,
  sms_cfg_if.sink   cfg_ch
);

  logic                       s1_valid;
  sms_pkg::stage_t            s1;
  logic                       out_ld;
  logic                       ram_we, ram_re;
  logic [sms_pkg::SLOT_W-1:0] ram_addr;
  sms_pkg::pair_t             ram_wdata, ram_rdata;

  sms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .out_ld    (out_ld),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata)
  );

  sms_ram #(
    .WIDTH (sms_pkg::NCH * sms_pkg::PS_W),
    .DEPTH (sms_pkg::SLOTS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_addr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_addr),
    .rd_data (ram_rdata)
  );

  sms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .ram_rdata (ram_rdata),
    .out_ld    (out_ld),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

@@ src/sms_checker.sv @@
// port-level assertions for the swizzled mip level stream, bound to the top level
// depends on sms_pkg and swizzled_mip_level_stream
`default_nettype none
module sms_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       cfg_ready,
  input wire logic                       reduced_valid,
  input wire logic [sms_pkg::RIDX_W-1:0] reduced_index,
  input wire logic [sms_pkg::CH_W-1:0]   reduced_red,
  input wire logic [sms_pkg::CH_W-1:0]   reduced_alpha
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // with the result register empty the input side must be open
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // an accepted pixel with an empty output is offered after the front-stage register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("pixel result missing");

  // no reduced pixel means reduced index, red and alpha are zero and cfg is ready
  a_red_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !reduced_valid |->
      reduced_index == '0 && reduced_red == '0 && reduced_alpha == '0 && cfg_ready)
    else $error("reduced fields not cleared");

endmodule

bind swizzled_mip_level_stream sms_checker u_sms_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .cfg_ready     (cfg_ch.ready),
  .reduced_valid (out_ch.reduced_valid),
  .reduced_index (out_ch.reduced_index),
  .reduced_red   (out_ch.reduced_red),
  .reduced_alpha (out_ch.reduced_alpha)
);
`default_nettype wire

@@ bench/sms_result_checker.sv @@
`timescale 1ns / 1ps
// result checker of the swizzled mip level stream: predicts every pixel beat and compares it
// depends on sms_pkg and sms_ifs; watches the pixel, result and register channels of the block
module sms_result_checker (
  input  logic clk,
  input  logic rst_n,
  sms_in_if    in_mon,
  sms_out_if   out_mon,
  sms_cfg_if   cfg_mon,
  output int   mismatches,
  output int   pending
);

  typedef struct {
    logic [sms_pkg::IDX_W-1:0]  swz_index;
    sms_pkg::pixel_t            px;
    logic                       avg_valid;
    logic [sms_pkg::RIDX_W-1:0] avg_index;
    sms_pkg::pixel_t            avg;
  } pixel_result_t;

  logic [sms_pkg::LOG2_W-1:0] width_log2;
  logic [sms_pkg::LOG2_W-1:0] height_log2;
  logic                       reduce_on;
  int                         col;
  int                         row;
  int                         pair_acc [4];
  // horizontal pair sums of the even row, one slot per column pair
  int                         line_sums [sms_pkg::SLOTS][4];
  pixel_result_t              due_pixels [$];
  pixel_result_t              want;
  int                         beat_no;

  function automatic int clamp_log2(input logic [sms_pkg::LOG2_W-1:0] v);
    return (v > sms_pkg::LOG2_LIMIT) ? int'(sms_pkg::LOG2_LIMIT) : int'(v);
  endfunction

  function automatic logic [31:0] interleave(input int x, input int y, input int s);
    logic [31:0] r;
    r = '0;
    for (int b = 0; b < s; b++) begin
      r[2*b+1] = x[b];
      r[2*b]   = y[b];
    end
    r |= 32'(x >> s) << (2 * s);
    r |= 32'(y >> s) << (2 * s);
    return r;
  endfunction

  function automatic pixel_result_t swizzle_and_filter(input sms_pkg::pixel_t px);
    pixel_result_t res;
    int            wl;
    int            hl;
    int            x;
    int            y;
    int            slot;
    int            ps [4];
    int            tot [4];
    bit            hready;
    bit            emit;
    wl = clamp_log2(width_log2);
    hl = clamp_log2(height_log2);
    x = col;
    y = row;
    hready = 1'b0;
    emit = 1'b0;
    res.swz_index = sms_pkg::IDX_W'(interleave(x, y, (wl < hl) ? wl : hl));
    res.px = px;
    res.avg_valid = 1'b0;
    res.avg_index = '0;
    res.avg = '0;
    if (reduce_on) begin
      // single column counts twice
      if (wl == 0) begin
        for (int c = 0; c < 4; c++) ps[c] = 2 * int'(px[c]);
        hready = 1'b1;
      end else if (x[0] == 1'b0) begin
        for (int c = 0; c < 4; c++) pair_acc[c] = int'(px[c]);
      end else begin
        for (int c = 0; c < 4; c++) ps[c] = pair_acc[c] + int'(px[c]);
        hready = 1'b1;
      end
      if (hready) begin
        slot = x >> 1;
        if (hl == 0) begin
          for (int c = 0; c < 4; c++) tot[c] = 2 * ps[c];
          emit = 1'b1;
        end else if (slot < sms_pkg::SLOTS) begin
          if (y[0] == 1'b0) begin
            for (int c = 0; c < 4; c++) line_sums[slot][c] = ps[c];
          end else begin
            for (int c = 0; c < 4; c++) tot[c] = line_sums[slot][c] + ps[c];
            emit = 1'b1;
          end
        end
      end
      if (emit) begin
        wl = (wl > 0) ? wl - 1 : 0;
        hl = (hl > 0) ? hl - 1 : 0;
        res.avg_valid = 1'b1;
        res.avg_index = sms_pkg::RIDX_W'(interleave(x >> 1, y >> 1, (wl < hl) ? wl : hl));
        for (int c = 0; c < 4; c++) res.avg[c] = 8'((tot[c] + 2) >> 2);
      end
    end
    x = col + 1;
    y = row;
    if (x >= (1 << clamp_log2(width_log2))) begin
      x = 0;
      y = y + 1;
      if (y >= (1 << clamp_log2(height_log2))) y = 0;
    end
    col = x;
    row = y;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    // keep the log short when everything goes wrong
    if (mismatches < 40) $display("result beat %0d: %s", beat_no, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_log2 = '0;
      height_log2 = '0;
      reduce_on = 1'b0;
      col = 0;
      row = 0;
      beat_no = 0;
      due_pixels.delete();
      pending = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        // a write to a known register restarts the level at pixel (0,0)
        case (cfg_mon.index)
          sms_pkg::REG_WIDTH_LOG2: begin
            width_log2 = cfg_mon.data;
            col = 0;
            row = 0;
          end
          sms_pkg::REG_HEIGHT_LOG2: begin
            height_log2 = cfg_mon.data;
            col = 0;
            row = 0;
          end
          sms_pkg::REG_REDUCE_ENABLE: begin
            reduce_on = cfg_mon.data[0];
            col = 0;
            row = 0;
          end
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        due_pixels.push_back(swizzle_and_filter({in_mon.alpha, in_mon.blue,
                                                 in_mon.green, in_mon.red}));
      if (out_mon.valid && out_mon.ready) begin
        if (due_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, swizzled_index 0x%0h",
                                    out_mon.swizzled_index));
        end else begin
          want = due_pixels.pop_front();
          compare_field("swizzled_index", out_mon.swizzled_index, want.swz_index);
          compare_field("out_red", out_mon.out_red, want.px[0]);
          compare_field("out_green", out_mon.out_green, want.px[1]);
          compare_field("out_blue", out_mon.out_blue, want.px[2]);
          compare_field("out_alpha", out_mon.out_alpha, want.px[3]);
          compare_field("reduced_valid", out_mon.reduced_valid, want.avg_valid);
          compare_field("reduced_index", out_mon.reduced_index, want.avg_index);
          compare_field("reduced_red", out_mon.reduced_red, want.avg[0]);
          compare_field("reduced_green", out_mon.reduced_green, want.avg[1]);
          compare_field("reduced_blue", out_mon.reduced_blue, want.avg[2]);
          compare_field("reduced_alpha", out_mon.reduced_alpha, want.avg[3]);
        end
        beat_no++;
      end
      pending = due_pixels.size();
    end
  end

endmodule

@@ bench/swizzled_mip_level_stream_tb.sv @@
`timescale 1ns / 1ps
// testbench top of the swizzled mip level stream: clock, reset, level setup and pixel stimulus
// depends on sms_pkg, sms_ifs, swizzled_mip_level_stream and sms_result_checker
module swizzled_mip_level_stream_tb;

  localparam logic [sms_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_PIXELS  = 600;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   pixels_sent = 0;
  int   quiet_cycles = 0;
  int   directed_pixels;

  sms_in_if  in_ch();
  sms_out_if out_ch();
  sms_cfg_if cfg_ch();

  swizzled_mip_level_stream u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sms_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ends the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int run;
      int gap;
      run = $urandom_range(1, 40);
      gap = idle_len();
      repeat (run) begin
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
    end
  end

  function automatic sms_pkg::pixel_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [7:0] a);
    return {a, b, g, r};
  endfunction

  function automatic sms_pkg::pixel_t random_pixel();
    sms_pkg::pixel_t px;
    int              r;
    for (int c = 0; c < 4; c++) begin
      r = $urandom_range(0, 9);
      px[c] = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom);
    end
    return px;
  endfunction

  function automatic int pick_log2();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) return $urandom_range(0, 3);
    if (r < 92) return $urandom_range(4, 6);
    return $urandom_range(13, 15);
  endfunction

  task automatic write_reg(input logic [sms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sms_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic send_pixel(input sms_pkg::pixel_t px);
    int gap;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.red   <= px[0];
    in_ch.green <= px[1];
    in_ch.blue  <= px[2];
    in_ch.alpha <= px[3];
    do @(posedge clk); while (!in_ch.ready);
    pixels_sent++;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // registers go in a rotated order with a random start; the upper data bits of the enable are don't-care
  task automatic set_level(input int wl, input int hl, input logic re);
    int start;
    drain();
    start = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      case ((start + k) % 3)
        0: write_reg(sms_pkg::REG_WIDTH_LOG2, sms_pkg::CFG_DAT_W'(wl));
        1: write_reg(sms_pkg::REG_HEIGHT_LOG2, sms_pkg::CFG_DAT_W'(hl));
        default: write_reg(sms_pkg::REG_REDUCE_ENABLE, {3'($urandom_range(0, 7)), re});
      endcase
    end
  endtask

  // mid-level pause; a write to the unused index must not restart the level
  task automatic pause_level();
    drain();
    write_reg(REG_UNUSED, sms_pkg::CFG_DAT_W'($urandom));
  endtask

  task automatic random_phase();
    int   wl;
    int   hl;
    int   area;
    int   count;
    int   pause_at;
    logic re;
    wl = pick_log2();
    hl = pick_log2();
    re = ($urandom_range(0, 3) != 0);
    set_level(wl, hl, re);
    area = (1 << ((wl > sms_pkg::DIM_LOG2) ? sms_pkg::DIM_LOG2 : wl)) *
           (1 << ((hl > sms_pkg::DIM_LOG2) ? sms_pkg::DIM_LOG2 : hl));
    // small levels run whole once or twice, sometimes wrapping into a partial repeat
    if (area <= 64)
      count = area * $urandom_range(1, 2) +
              (($urandom_range(0, 2) == 0) ? $urandom_range(1, area) : 0);
    else
      count = $urandom_range(1, 96);
    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) pause_level();
      send_pixel(random_pixel());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    in_ch.alpha = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 2x2 level: extremes and rounding, then a second pass with a pause inside
    set_level(1, 1, 1'b1);
    send_pixel(mk_pixel(8'h00, 8'hff, 8'h80, 8'h7f));
    send_pixel(mk_pixel(8'hff, 8'h00, 8'h01, 8'hfe));
    send_pixel(mk_pixel(8'hff, 8'hff, 8'h00, 8'h01));
    send_pixel(mk_pixel(8'h01, 8'h00, 8'hff, 8'hff));
    send_pixel(mk_pixel(8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(mk_pixel(8'hff, 8'hff, 8'hff, 8'hff));
    pause_level();
    send_pixel(mk_pixel(8'hff, 8'hff, 8'hff, 8'hfe));
    send_pixel(mk_pixel(8'hfe, 8'hfd, 8'h02, 8'h01));
    // one by one level
    set_level(0, 0, 1'b1);
    repeat (2) send_pixel(random_pixel());
    // single row, then single column
    set_level(2, 0, 1'b1);
    repeat (4) send_pixel(random_pixel());
    set_level(0, 2, 1'b1);
    repeat (4) send_pixel(random_pixel());
    // oversized sizes saturate
    set_level(15, 13, 1'b0);
    repeat (3) send_pixel(random_pixel());
    set_level(12, 12, 1'b1);
    repeat (2) send_pixel(random_pixel());
    directed_pixels = pixels_sent;

    while (pixels_sent < directed_pixels + RANDOM_PIXELS) random_phase();

    drain();
    if (mismatches == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ swizzled_mip_level_stream.f @@
src/sms_pkg.sv
src/sms_ifs.sv
src/sms_ram.sv
src/sms_front.sv
src/sms_back.sv
src/swizzled_mip_level_stream.sv
src/sms_checker.sv
bench/sms_result_checker.sv
bench/swizzled_mip_level_stream_tb.sv
